// ===== hdl/mwm_pkg.sv =====
package mwm_pkg;

	localparam int VEL_W      = 16;
	localparam int LIM_W      = 15;
	localparam int SUM_W      = 18;
	localparam int MAG_W      = 17;
	localparam int PROD_W     = MAG_W + LIM_W;
	localparam int QUO_W      = PROD_W - MAG_W;
	localparam int WHEEL_W    = 16;
	localparam int NUM_WHEELS = 4;

	localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd8000;

	// quotient bits resolved per divider stage
	localparam int DIV_STEPS_DEFAULT = 3;

	localparam int WHEEL_LF = 0;
	localparam int WHEEL_RF = 1;
	localparam int WHEEL_LB = 2;
	localparam int WHEEL_RB = 3;

	typedef struct packed {
		logic [MAG_W-1:0]   rem;
		logic [QUO_W-1:0]   dvd;
		logic [QUO_W-1:0]   quo;
		logic               neg;
		logic [WHEEL_W-1:0] raw;
	} lane_t;

	typedef struct packed {
		lane_t [NUM_WHEELS-1:0] lane;
		logic [MAG_W-1:0]       peak;
		logic                   scale;
	} div_t;

endpackage

// ===== hdl/mwm_front.sv =====
module mwm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mwm_pkg::LIM_W-1:0]  speed_limit,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [mwm_pkg::VEL_W-1:0] vel_forward,
	input  logic signed [mwm_pkg::VEL_W-1:0] vel_sideways,
	input  logic signed [mwm_pkg::VEL_W-1:0] vel_rotate,
	output logic                       out_valid,
	input  logic                       out_ready,
	output mwm_pkg::div_t              out_data
);
	import mwm_pkg::*;

	function automatic logic signed [VEL_W-1:0] clamp_sym(
		input logic signed [VEL_W-1:0] v,
		input logic [LIM_W-1:0]        lim
	);
		logic signed [VEL_W:0] ext;
		logic signed [VEL_W:0] hi;
		logic signed [VEL_W:0] lo;
		ext = {v[VEL_W-1], v};
		hi  = $signed({2'b00, lim});
		lo  = -hi;
		if (ext > hi) begin
			clamp_sym = hi[VEL_W-1:0];
		end else if (ext < lo) begin
			clamp_sym = lo[VEL_W-1:0];
		end else begin
			clamp_sym = v;
		end
	endfunction

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [VEL_W-1:0] x_s1, y_s1, w_s1;
	logic signed [SUM_W-1:0] sum_s2 [NUM_WHEELS];
	logic [MAG_W-1:0]        mag_s3 [NUM_WHEELS];
	logic                    neg_s3 [NUM_WHEELS];
	logic [WHEEL_W-1:0]      raw_s3 [NUM_WHEELS];
	div_t                    data_s4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// s1: clamp translation
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1 <= clamp_sym(vel_forward, speed_limit);
			y_s1 <= clamp_sym(vel_sideways, speed_limit);
			w_s1 <= vel_rotate;
		end
	end

	// s2: raw wheel sums
	logic signed [SUM_W-1:0] xe, ye, we;
	assign xe = {{(SUM_W-VEL_W){x_s1[VEL_W-1]}}, x_s1};
	assign ye = {{(SUM_W-VEL_W){y_s1[VEL_W-1]}}, y_s1};
	assign we = {{(SUM_W-VEL_W){w_s1[VEL_W-1]}}, w_s1};

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sum_s2[WHEEL_LF] <= xe + ye + we;
			sum_s2[WHEEL_RF] <= xe - ye - we;
			sum_s2[WHEEL_LB] <= xe - ye + we;
			sum_s2[WHEEL_RB] <= xe + ye - we;
		end
	end

	// s3: magnitude and sign
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				neg_s3[i] <= sum_s2[i][SUM_W-1];
				raw_s3[i] <= sum_s2[i][WHEEL_W-1:0];
				if (sum_s2[i][SUM_W-1]) begin
					mag_s3[i] <= MAG_W'(-sum_s2[i]);
				end else begin
					mag_s3[i] <= sum_s2[i][MAG_W-1:0];
				end
			end
		end
	end

	// s4: scaled numerators, peak and scale decision
	logic [MAG_W-1:0]  pk01, pk23, peak;
	logic [PROD_W-1:0] prod [NUM_WHEELS];

	always_comb begin
		pk01 = (mag_s3[0] > mag_s3[1]) ? mag_s3[0] : mag_s3[1];
		pk23 = (mag_s3[2] > mag_s3[3]) ? mag_s3[2] : mag_s3[3];
		peak = (pk01 > pk23) ? pk01 : pk23;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			prod[i] = PROD_W'(mag_s3[i]) * PROD_W'(speed_limit);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			data_s4.peak  <= peak;
			data_s4.scale <= peak > {2'b00, speed_limit};
			for (int i = 0; i < NUM_WHEELS; i++) begin
				data_s4.lane[i].rem <= prod[i][PROD_W-1:QUO_W];
				data_s4.lane[i].dvd <= prod[i][QUO_W-1:0];
				data_s4.lane[i].quo <= '0;
				data_s4.lane[i].neg <= neg_s3[i];
				data_s4.lane[i].raw <= raw_s3[i];
			end
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

// ===== hdl/mwm_div_stage.sv =====
module mwm_div_stage #(
	parameter int STEPS = mwm_pkg::DIV_STEPS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mwm_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mwm_pkg::div_t out_data
);
	import mwm_pkg::*;

	logic v_s1;
	div_t data_s1;
	div_t nxt;

	// restoring division, STEPS quotient bits per lane
	always_comb begin
		logic [MAG_W:0] t;
		logic           qb;
		nxt = in_data;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			for (int s = 0; s < STEPS; s++) begin
				t  = {nxt.lane[i].rem, nxt.lane[i].dvd[QUO_W-1]};
				qb = t >= {1'b0, nxt.peak};
				if (qb) t = t - {1'b0, nxt.peak};
				nxt.lane[i].dvd = {nxt.lane[i].dvd[QUO_W-2:0], 1'b0};
				nxt.lane[i].rem = t[MAG_W-1:0];
				nxt.lane[i].quo = {nxt.lane[i].quo[QUO_W-2:0], qb};
			end
		end
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = data_s1;

endmodule

// ===== hdl/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer: one chassis command in, four wheel speeds out.
// Command channel: cmd_valid / cmd_stall with vel_forward, vel_sideways,
// vel_rotate. Wheel channel: wheel_valid / wheel_stall with the four wheel
// speeds. An item moves at a clock edge with valid high and stall low.
// speed_limit is written through limit_we / limit_data; the user must write
// it only while no item is in flight, as the block does not enforce this.
// It resets to 8000. With the default divider the pipeline has 4 front
// stages (clamp, sums, magnitudes, multiply and peak), 5 divider stages of
// 3 quotient bits each and 1 output register. One item per cycle is
// sustained while wheel_stall is low; the rate is set by the fully
// pipelined restoring divider, one per wheel.
// When wheel_stall is high, items collect in the empty stages; cmd_stall
// rises only once every stage holds an item.
// arst_n clears all stage valid bits and reloads the speed limit.
module mecanum_wheel_mixer #(
	parameter int DIV_STEPS = mwm_pkg::DIV_STEPS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 limit_we,
	input  logic [mwm_pkg::LIM_W-1:0]            limit_data,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic signed [mwm_pkg::VEL_W-1:0]     vel_forward,
	input  logic signed [mwm_pkg::VEL_W-1:0]     vel_sideways,
	input  logic signed [mwm_pkg::VEL_W-1:0]     vel_rotate,
	output logic                                 wheel_valid,
	input  logic                                 wheel_stall,
	output logic signed [mwm_pkg::WHEEL_W-1:0]   wheel_left_front,
	output logic signed [mwm_pkg::WHEEL_W-1:0]   wheel_right_front,
	output logic signed [mwm_pkg::WHEEL_W-1:0]   wheel_left_back,
	output logic signed [mwm_pkg::WHEEL_W-1:0]   wheel_right_back
);
	import mwm_pkg::*;

	localparam int NSTAGE = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

	logic [LIM_W-1:0] speed_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			speed_limit_q <= limit_data;
		end
	end

	logic front_ready;
	div_t dchain [NSTAGE+1];
	logic dv     [NSTAGE+1];
	logic dr     [NSTAGE+1];

	mwm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.speed_limit  (speed_limit_q),
		.in_valid     (cmd_valid),
		.in_ready     (front_ready),
		.vel_forward  (vel_forward),
		.vel_sideways (vel_sideways),
		.vel_rotate   (vel_rotate),
		.out_valid    (dv[0]),
		.out_ready    (dr[0]),
		.out_data     (dchain[0])
	);

	assign cmd_stall = !front_ready;

	for (genvar g = 0; g < NSTAGE; g++) begin : g_div
		// last stage takes whatever bits remain
		localparam int ST = (g == NSTAGE - 1) ? QUO_W - (NSTAGE - 1) * DIV_STEPS : DIV_STEPS;
		mwm_div_stage #(.STEPS(ST)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[g]),
			.in_ready  (dr[g]),
			.in_data   (dchain[g]),
			.out_valid (dv[g+1]),
			.out_ready (dr[g+1]),
			.out_data  (dchain[g+1])
		);
	end

	// output register: apply sign to quotient, or pass the raw sum
	logic               out_v_q;
	logic [WHEEL_W-1:0] wheel_q [NUM_WHEELS];
	div_t               last;

	assign last         = dchain[NSTAGE];
	assign dr[NSTAGE]   = !out_v_q || !wheel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (dr[NSTAGE]) begin
			out_v_q <= dv[NSTAGE];
		end
	end

	always_ff @(posedge clk) begin
		if (dr[NSTAGE] && dv[NSTAGE]) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				if (!last.scale) begin
					wheel_q[i] <= last.lane[i].raw;
				end else if (last.lane[i].neg) begin
					wheel_q[i] <= -{1'b0, last.lane[i].quo};
				end else begin
					wheel_q[i] <= {1'b0, last.lane[i].quo};
				end
			end
		end
	end

	assign wheel_valid       = out_v_q;
	assign wheel_left_front  = wheel_q[WHEEL_LF];
	assign wheel_right_front = wheel_q[WHEEL_RF];
	assign wheel_left_back   = wheel_q[WHEEL_LB];
	assign wheel_right_back  = wheel_q[WHEEL_RB];

	// a finished scaled division leaves quotient and remainder below the peak
	logic div_ok;
	always_comb begin
		div_ok = 1'b1;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if ({2'b00, last.lane[i].quo} >= last.peak) div_ok = 1'b0;
			if (last.lane[i].rem >= last.peak) div_ok = 1'b0;
		end
	end

	a_div_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(dv[NSTAGE] && last.scale) |-> div_ok)
		else $error("divider result out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (wheel_valid && wheel_stall))
		else $error("command stalled while pipeline has room");

endmodule
